// ===== rtl/lc2k_pkg.sv =====
// shared types, constants and opcodes of the lc2k instruction step unit
`default_nettype none

package lc2k_pkg;

   // memory size: word address width, power-of-two depth
   localparam int MEM_AW    = 16;
   localparam int MEM_WORDS = 1 << MEM_AW;

   // register file
   localparam int REG_AW    = 3;
   localparam int REG_COUNT = 1 << REG_AW;

   // item operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EXEC = 1'b1;

   // instruction opcodes
   typedef enum logic [2:0] {
      OPC_ADD  = 3'd0,
      OPC_NAND = 3'd1,
      OPC_LW   = 3'd2,
      OPC_SW   = 3'd3,
      OPC_BEQ  = 3'd4,
      OPC_JALR = 3'd5,
      OPC_HALT = 3'd6,
      OPC_NOOP = 3'd7
   } opcode_type;

   // input item
   typedef struct packed {
      logic               operation;
      logic [15:0]        load_address;
      logic signed [31:0] load_data;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [15:0]        program_counter;
      logic               halted;
      logic               reg_write_valid;
      logic [2:0]         reg_write_index;
      logic signed [31:0] reg_write_value;
      logic               mem_write_valid;
      logic [15:0]        mem_write_address;
      logic signed [31:0] mem_write_value;
   } rsp_item_type;

   // main memory access
   typedef struct packed {
      logic              en;
      logic              we;
      logic [MEM_AW-1:0] addr;
      logic [31:0]       wdata;
   } mem_req_type;

   // register file read
   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr_a;
      logic [REG_AW-1:0] addr_b;
   } rf_rd_type;

   // register file write
   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] idx;
      logic [31:0]       data;
   } rf_wr_type;

endpackage

`default_nettype wire

// ===== rtl/lc2k_mem.sv =====
// main memory: single-port synchronous ram with a zeroing sweep after reset
`default_nettype none

module lc2k_mem
   import lc2k_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mem_req_type mem_req,
   output logic [31:0]      mem_rdata,
   output logic             clear_busy
);

   logic [31:0]       mem_array [MEM_WORDS];
   logic [31:0]       rdata_ff;
   logic              clearing_ff;
   logic              clearing_in;
   logic [MEM_AW-1:0] clr_addr_ff;
   logic [MEM_AW-1:0] clr_addr_in;

   // zeroing sweep control
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + MEM_AW'(1);
         if (clr_addr_ff == MEM_AW'(MEM_WORDS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ram port: sweep writes take priority, reads registered
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem_array[clr_addr_ff] <= '0;
      end else if (mem_req.en && mem_req.we) begin
         mem_array[mem_req.addr] <= mem_req.wdata;
      end else if (mem_req.en) begin
         rdata_ff <= mem_array[mem_req.addr];
      end
   end

   assign mem_rdata  = rdata_ff;
   assign clear_busy = clearing_ff;

endmodule

`default_nettype wire

// ===== rtl/lc2k_regs.sv =====
// register file: eight words, two registered read ports, one write port
`default_nettype none

module lc2k_regs
   import lc2k_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire rf_rd_type rf_rd,
   input  wire rf_wr_type rf_wr,
   output logic [31:0]    rdata_a,
   output logic [31:0]    rdata_b
);

   logic [31:0]          reg_array [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [31:0]          rdata_a_ff;
   logic [31:0]          rdata_b_ff;

   // per-entry valid bits, an unwritten register reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (rf_wr.en) begin
         valid_ff[rf_wr.idx] <= 1'b1;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (rf_wr.en) begin
         reg_array[rf_wr.idx] <= rf_wr.data;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      if (rf_rd.en) begin
         rdata_a_ff <= valid_ff[rf_rd.addr_a] ? reg_array[rf_rd.addr_a] : '0;
         rdata_b_ff <= valid_ff[rf_rd.addr_b] ? reg_array[rf_rd.addr_b] : '0;
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// ===== rtl/lc2k_seq.sv =====
// step sequencer: fetch, decode, execute and write back, holds pc and halt flag
`default_nettype none

module lc2k_seq
   import lc2k_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         clear_busy,
   input  wire logic         hold_valid,
   input  wire req_item_type hold_item,
   input  wire logic         rsp_free,
   input  wire logic [31:0]  mem_rdata,
   input  wire logic [31:0]  rf_rdata_a,
   input  wire logic [31:0]  rf_rdata_b,
   output logic              take,
   output mem_req_type       mem_req,
   output rf_rd_type         rf_rd,
   output rf_wr_type         rf_wr,
   output logic              done,
   output rsp_item_type      result
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [MEM_AW-1:0] pc_ff;
   logic [MEM_AW-1:0] pc_in;
   logic              halt_ff;
   logic              halt_in;
   logic [31:0]       instr_ff;
   logic [31:0]       instr_in;

   // decoded fields of the held instruction
   opcode_type        opcode;
   logic [REG_AW-1:0] idx_a;
   logic [REG_AW-1:0] idx_b;
   logic [15:0]       field;
   logic [31:0]       offset;
   logic [31:0]       data_sum;
   logic [MEM_AW-1:0] pc_inc;
   logic              mem_wr;

   always_comb begin
      opcode   = opcode_type'(instr_ff[24:22]);
      idx_a    = instr_ff[21:19];
      idx_b    = instr_ff[18:16];
      field    = instr_ff[15:0];
      offset   = {{16{field[15]}}, field};
      data_sum = rf_rdata_b + offset;
      pc_inc   = pc_ff + MEM_AW'(1);
   end

   // next-state and datapath control
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      halt_in  = halt_ff;
      instr_in = instr_ff;
      take     = 1'b0;
      done     = 1'b0;
      mem_req  = '0;
      rf_rd    = '0;
      rf_wr    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (hold_valid && !clear_busy) begin
               if (hold_item.operation == OP_LOAD) begin
                  // program load stores and reports at once
                  if (rsp_free) begin
                     take          = 1'b1;
                     done          = 1'b1;
                     mem_req.en    = 1'b1;
                     mem_req.we    = 1'b1;
                     mem_req.addr  = hold_item.load_address[MEM_AW-1:0];
                     mem_req.wdata = hold_item.load_data;
                  end
               end else if (halt_ff) begin
                  // halted machine: report state, change nothing
                  if (rsp_free) begin
                     take = 1'b1;
                     done = 1'b1;
                  end
               end else begin
                  // fetch mem[pc]
                  take         = 1'b1;
                  mem_req.en   = 1'b1;
                  mem_req.addr = pc_ff;
                  state_in     = ST_DECODE;
               end
            end
         end

         ST_DECODE: begin
            instr_in     = mem_rdata;
            rf_rd.en     = 1'b1;
            rf_rd.addr_a = mem_rdata[21:19];
            rf_rd.addr_b = mem_rdata[18:16];
            state_in     = ST_EXEC;
         end

         ST_EXEC: begin
            if (opcode == OPC_LW) begin
               mem_req.en   = 1'b1;
               mem_req.addr = data_sum[MEM_AW-1:0];
               state_in     = ST_LOAD;
            end else if (rsp_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
               pc_in    = pc_inc;
               case (opcode)
                  OPC_ADD: begin
                     rf_wr.en   = 1'b1;
                     rf_wr.idx  = field[REG_AW-1:0];
                     rf_wr.data = rf_rdata_a + rf_rdata_b;
                  end
                  OPC_NAND: begin
                     rf_wr.en   = 1'b1;
                     rf_wr.idx  = field[REG_AW-1:0];
                     rf_wr.data = ~(rf_rdata_a & rf_rdata_b);
                  end
                  OPC_SW: begin
                     mem_req.en    = 1'b1;
                     mem_req.we    = 1'b1;
                     mem_req.addr  = data_sum[MEM_AW-1:0];
                     mem_req.wdata = rf_rdata_a;
                  end
                  OPC_BEQ: begin
                     if (rf_rdata_a == rf_rdata_b) begin
                        pc_in = pc_inc + offset[MEM_AW-1:0];
                     end
                  end
                  OPC_JALR: begin
                     // link written first, so equal indexes jump to pc + 1
                     rf_wr.en   = 1'b1;
                     rf_wr.idx  = idx_a;
                     rf_wr.data = 32'(pc_inc);
                     pc_in      = (idx_a == idx_b) ? pc_inc : rf_rdata_b[MEM_AW-1:0];
                  end
                  OPC_HALT: begin
                     halt_in = 1'b1;
                     pc_in   = pc_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_LOAD: begin
            if (rsp_free) begin
               done       = 1'b1;
               state_in   = ST_IDLE;
               pc_in      = pc_inc;
               rf_wr.en   = 1'b1;
               rf_wr.idx  = idx_a;
               rf_wr.data = mem_rdata;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result fields, zero where nothing was written
   always_comb begin
      mem_wr                   = mem_req.en && mem_req.we;
      result                   = '0;
      result.program_counter   = 16'(pc_in);
      result.halted            = halt_in;
      result.reg_write_valid   = rf_wr.en;
      result.reg_write_index   = rf_wr.idx;
      result.reg_write_value   = rf_wr.data;
      result.mem_write_valid   = mem_wr;
      result.mem_write_address = mem_wr ? 16'(mem_req.addr) : '0;
      result.mem_write_value   = mem_wr ? mem_req.wdata : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         halt_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         halt_ff  <= halt_in;
      end
      instr_ff <= instr_in;
   end

endmodule

`default_nettype wire

// ===== rtl/lc2k_instruction_step_unit.sv =====
// top level of the lc2k instruction step unit: input buffer, result register, units
//
//   channel   ports                             direction   payload
//   request   req_valid req_stall req_item      in          req_item_type
//   response  rsp_valid rsp_stall rsp_item      out         rsp_item_type
//
// an execute item passes the sequencer states fetch, register read and execute,
// plus a data read for a load word, since the single main memory port serves fetch and data
// a program load item or an item on a halted machine is handled in the idle state alone
// after reset the main memory is zeroed, one word a cycle, all 65536 words, under req_stall
// a one-item input buffer takes the next item while the current one runs;
// a held result stalls the sequencer only at its finishing cycle
`default_nettype none

module lc2k_instruction_step_unit
   import lc2k_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);

   logic         hold_valid_ff;
   logic         hold_valid_in;
   req_item_type hold_item_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;

   logic         clear_busy;
   logic         take;
   logic         done;
   logic         rsp_free;
   logic         req_accept;
   rsp_item_type result;
   mem_req_type  mem_req;
   logic [31:0]  mem_rdata;
   rf_rd_type    rf_rd;
   rf_wr_type    rf_wr;
   logic [31:0]  rf_rdata_a;
   logic [31:0]  rf_rdata_b;

   // input buffer handshake
   assign req_stall  = clear_busy || (hold_valid_ff && !take);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_accept) begin
         hold_valid_in = 1'b1;
      end else if (take) begin
         hold_valid_in = 1'b0;
      end
   end

   // result register
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (req_accept) begin
         hold_item_ff <= req_item;
      end
      if (done) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // units
   lc2k_mem u_mem (
      .clock      (clock),
      .reset      (reset),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata),
      .clear_busy (clear_busy)
   );

   lc2k_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .rf_rd   (rf_rd),
      .rf_wr   (rf_wr),
      .rdata_a (rf_rdata_a),
      .rdata_b (rf_rdata_b)
   );

   lc2k_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .hold_valid (hold_valid_ff),
      .hold_item  (hold_item_ff),
      .rsp_free   (rsp_free),
      .mem_rdata  (mem_rdata),
      .rf_rdata_a (rf_rdata_a),
      .rf_rdata_b (rf_rdata_b),
      .take       (take),
      .mem_req    (mem_req),
      .rf_rd      (rf_rd),
      .rf_wr      (rf_wr),
      .done       (done),
      .result     (result)
   );

endmodule

`default_nettype wire
